FILE: design/water_heater_thermostat_top_assert.svh
// assertion macros shared by the thermostat modules
`ifndef WATER_HEATER_THERMOSTAT_TOP_ASSERT_SVH
`define WATER_HEATER_THERMOSTAT_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define WHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define WHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/wht_pkg.sv
// shared types and constants for the water heater thermostat
package wht_pkg;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned COEF_W  = 24;
  localparam int unsigned BAND_W  = 15;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_QUAD   = 3'd0;
  localparam logic [2:0] REG_LIN    = 3'd1;
  localparam logic [2:0] REG_OFFSET = 3'd2;
  localparam logic [2:0] REG_BAND   = 3'd3;
  localparam logic [2:0] REG_MARGIN = 3'd4;

  localparam logic signed [COEF_W-1:0] QUAD_RST   = -24'sd1620;
  localparam logic signed [COEF_W-1:0] LIN_RST    = -24'sd1406;
  localparam logic signed [COEF_W-1:0] OFFSET_RST = 24'sd33293;
  localparam logic [BAND_W-1:0]        BAND_RST   = 15'd1280;
  localparam logic [BAND_W-1:0]        MARGIN_RST = 15'd1280;

  // temperatures in 1/256 degC
  localparam logic [BAND_W-1:0] DEG_38  = 15'd9728;
  localparam logic [BAND_W-1:0] DEG_58  = 15'd14848;
  localparam logic [BAND_W-1:0] DEG_78  = 15'd19968;
  localparam logic [BAND_W-1:0] DEG_98  = 15'd25088;
  localparam logic [BAND_W-1:0] DEG_40  = 15'd10240;
  localparam logic [BAND_W-1:0] DEG_60  = 15'd15360;
  localparam logic [BAND_W-1:0] DEG_80  = 15'd20480;
  localparam logic [BAND_W-1:0] DEG_100 = 15'd25600;

  // setpoint index codes
  localparam logic [1:0] SP_100 = 2'd0;
  localparam logic [1:0] SP_80  = 2'd1;
  localparam logic [1:0] SP_60  = 2'd2;
  localparam logic [1:0] SP_40  = 2'd3;

  typedef struct packed {
    logic signed [COEF_W-1:0] quad;
    logic signed [COEF_W-1:0] lin;
    logic signed [COEF_W-1:0] offset;
    logic [BAND_W-1:0]        band;
    logic [BAND_W-1:0]        margin;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_QUAD,
    OP_LIN,
    OP_COMMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  function automatic logic [BAND_W-1:0] setpoint_fn(input logic [1:0] idx);
    logic [BAND_W-1:0] sp;
    case (idx)
      SP_100:  sp = DEG_100;
      SP_80:   sp = DEG_80;
      SP_60:   sp = DEG_60;
      SP_40:   sp = DEG_40;
      default: sp = DEG_100;
    endcase
    return sp;
  endfunction

endpackage

FILE: design/wht_cfg.sv
// configuration register file behind the apb-style port
module wht_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wht_pkg::PADDR_W-1:0] paddr,
  input  logic [wht_pkg::PDATA_W-1:0] pwdata,
  output logic [wht_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output wht_pkg::cfg_t               cfg_o
);

  wht_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quad   <= wht_pkg::QUAD_RST;
      cfg_q.lin    <= wht_pkg::LIN_RST;
      cfg_q.offset <= wht_pkg::OFFSET_RST;
      cfg_q.band   <= wht_pkg::BAND_RST;
      cfg_q.margin <= wht_pkg::MARGIN_RST;
    end else if (wr_en) begin
      case (idx)
        wht_pkg::REG_QUAD:   cfg_q.quad   <= pwdata[wht_pkg::COEF_W-1:0];
        wht_pkg::REG_LIN:    cfg_q.lin    <= pwdata[wht_pkg::COEF_W-1:0];
        wht_pkg::REG_OFFSET: cfg_q.offset <= pwdata[wht_pkg::COEF_W-1:0];
        wht_pkg::REG_BAND:   cfg_q.band   <= pwdata[wht_pkg::BAND_W-1:0];
        wht_pkg::REG_MARGIN: cfg_q.margin <= pwdata[wht_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // readback, coefficients sign extended
  always_comb begin
    case (idx)
      wht_pkg::REG_QUAD:   prdata = wht_pkg::PDATA_W'(cfg_q.quad);
      wht_pkg::REG_LIN:    prdata = wht_pkg::PDATA_W'(cfg_q.lin);
      wht_pkg::REG_OFFSET: prdata = wht_pkg::PDATA_W'(cfg_q.offset);
      wht_pkg::REG_BAND:   prdata = wht_pkg::PDATA_W'(cfg_q.band);
      wht_pkg::REG_MARGIN: prdata = wht_pkg::PDATA_W'(cfg_q.margin);
      default:             prdata = '0;
    endcase
  end

endmodule

FILE: design/wht_ctrl.sv
// sequencing state machine and output valid for the thermostat
`include "water_heater_thermostat_top_assert.svh"

module wht_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wht_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_QUAD,
    S_LIN,
    S_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   can_commit;
  logic   commit;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign can_commit  = !out_valid_q || !out_stall_i;
  assign commit      = (state_q == S_FIN) && can_commit;

  always_comb begin
    case (state_q)
      S_IDLE:  cmd_o.op = in_valid_i ? wht_pkg::OP_LOAD : wht_pkg::OP_NONE;
      S_QUAD:  cmd_o.op = wht_pkg::OP_QUAD;
      S_LIN:   cmd_o.op = wht_pkg::OP_LIN;
      S_FIN:   cmd_o.op = can_commit ? wht_pkg::OP_COMMIT : wht_pkg::OP_NONE;
      default: cmd_o.op = wht_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_QUAD;
          end
        end
        S_QUAD: state_q <= S_LIN;
        S_LIN:  state_q <= S_FIN;
        S_FIN: begin
          if (can_commit) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `WHT_ASSERT_NEXT(a_accept_starts_quad, in_valid_i && !in_stall_o, state_q == S_QUAD, "accepted request did not start the quadratic term")
  `WHT_ASSERT_NEXT(a_commit_shows_result, commit, out_valid_q && state_q == S_IDLE, "committed result not presented")

endmodule

FILE: design/wht_dp.sv
// datapath: shared multiplier, temperature accumulator, control state and result registers
`include "water_heater_thermostat_top_assert.svh"

module wht_dp #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wht_pkg::cmd_t                       cmd_i,
  input  wht_pkg::cfg_t                       cfg_i,
  input  logic                                reheat_button_i,
  input  logic                                select_button_i,
  input  logic                                power_button_i,
  input  logic [ADC_BITS-1:0]                 adc_sample_i,
  input  logic                                blink_slow_i,
  input  logic                                blink_horn_i,
  output logic                                heater_drive_o,
  output logic                                led_power_o,
  output logic                                led_reheat_o,
  output logic                                led_forty_o,
  output logic                                led_sixty_o,
  output logic                                led_eighty_o,
  output logic                                led_hundred_o,
  output logic                                horn_on_o,
  output logic signed [15:0]                  temperature_o
);

  localparam int unsigned SQ_W    = 2 * ADC_BITS;
  localparam int unsigned MUL_A_W = SQ_W + 1;
  localparam int unsigned MUL_W   = MUL_A_W + wht_pkg::COEF_W;
  localparam int unsigned ACC_W   = MUL_W - 7;

  localparam logic signed [ACC_W-1:0] T_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] T_MIN = ACC_W'(-32768);

  // latched request
  logic                 rb_q, sb_q, pb_q, bs_q, bh_q;
  logic [ADC_BITS-1:0]  d_q;
  logic [SQ_W-1:0]      sq_q;
  logic signed [ACC_W-1:0] acc_q;

  // control state
  logic rb_prev_q, sb_prev_q, pb_prev_q;
  logic heater_q, power_q, reheat_q;
  logic [1:0] idx_q;

  // shared multiplier
  logic signed [MUL_A_W-1:0]         mul_a;
  logic signed [wht_pkg::COEF_W-1:0] mul_b;
  logic signed [MUL_W-1:0]           prod;
  logic signed [ACC_W-1:0]           quad_term;
  logic signed [ACC_W-1:0]           lin_term;

  // commit logic
  logic e1, e2, e3;
  logic heater_n, power_n, reheat_n;
  logic [1:0] idx_n;
  logic signed [ACC_W-1:0] sp_old, sp_new, band, margin;
  logic signed [ACC_W-1:0] th38, th58, th78, th98;
  logic l40, l60, l80, l100, horn;
  logic signed [15:0] t_sat;

  always_comb begin
    case (cmd_i.op)
      wht_pkg::OP_LOAD: begin
        mul_a = MUL_A_W'(adc_sample_i);
        mul_b = wht_pkg::COEF_W'(adc_sample_i);
      end
      wht_pkg::OP_QUAD: begin
        mul_a = MUL_A_W'(sq_q);
        mul_b = cfg_i.quad;
      end
      default: begin
        mul_a = MUL_A_W'(d_q);
        mul_b = cfg_i.lin;
      end
    endcase
  end

  assign prod      = mul_a * mul_b;
  // arithmetic shifts round toward minus infinity
  assign quad_term = ACC_W'($signed(prod[MUL_W-1:16]));
  assign lin_term  = ACC_W'($signed(prod[MUL_W-1:8]));

  assign e1 = rb_q & ~rb_prev_q;
  assign e2 = sb_q & ~sb_prev_q;
  assign e3 = pb_q & ~pb_prev_q;

  assign sp_old = ACC_W'(wht_pkg::setpoint_fn(idx_q));
  assign band   = ACC_W'(cfg_i.band);
  assign margin = ACC_W'(cfg_i.margin);
  assign th38   = ACC_W'(wht_pkg::DEG_38);
  assign th58   = ACC_W'(wht_pkg::DEG_58);
  assign th78   = ACC_W'(wht_pkg::DEG_78);
  assign th98   = ACC_W'(wht_pkg::DEG_98);

  always_comb begin
    heater_n = heater_q;
    power_n  = power_q;
    if (!heater_q && (acc_q < sp_old - band) && power_q) begin
      heater_n = 1'b1;
    end else if ((heater_q && (acc_q >= sp_old)) || !power_q) begin
      heater_n = 1'b0;
      if (!reheat_q) begin
        power_n = 1'b0;
      end
    end
    if (e3) begin
      power_n = ~power_n;
    end
    reheat_n = power_n & (reheat_q ^ e1);
    idx_n    = power_n ? idx_q : wht_pkg::SP_100;
    if (e2) begin
      idx_n = idx_n + 2'd1;
    end
  end

  assign sp_new = ACC_W'(wht_pkg::setpoint_fn(idx_n));
  assign l40  = (((idx_n == wht_pkg::SP_40) && bs_q) || (acc_q >= th38)) && power_n;
  assign l60  = (((idx_n == wht_pkg::SP_60) && bs_q) || (acc_q >= th58)) && power_n;
  assign l80  = (((idx_n == wht_pkg::SP_80) && bs_q) || (acc_q >= th78)) && power_n;
  assign l100 = (((idx_n == wht_pkg::SP_100) && bs_q) || (acc_q >= th98)) && power_n;
  assign horn = (acc_q >= sp_new - margin) && bh_q;

  always_comb begin
    if (acc_q > T_MAX) begin
      t_sat = 16'sh7fff;
    end else if (acc_q < T_MIN) begin
      t_sat = -16'sh8000;
    end else begin
      t_sat = acc_q[15:0];
    end
  end

  // request and arithmetic registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      wht_pkg::OP_LOAD: begin
        rb_q <= reheat_button_i;
        sb_q <= select_button_i;
        pb_q <= power_button_i;
        bs_q <= blink_slow_i;
        bh_q <= blink_horn_i;
        d_q  <= adc_sample_i;
        sq_q <= prod[SQ_W-1:0];
      end
      wht_pkg::OP_QUAD: acc_q <= quad_term + ACC_W'(cfg_i.offset);
      wht_pkg::OP_LIN:  acc_q <= acc_q + lin_term;
      default: ;
    endcase
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == wht_pkg::OP_COMMIT) begin
      heater_drive_o <= heater_n;
      led_power_o    <= power_n;
      led_reheat_o   <= reheat_n;
      led_forty_o    <= l40;
      led_sixty_o    <= l60;
      led_eighty_o   <= l80;
      led_hundred_o  <= l100;
      horn_on_o      <= horn;
      temperature_o  <= t_sat;
    end
  end

  // thermostat and button state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_prev_q <= 1'b1;
      sb_prev_q <= 1'b1;
      pb_prev_q <= 1'b1;
      heater_q  <= 1'b0;
      power_q   <= 1'b0;
      reheat_q  <= 1'b0;
      idx_q     <= wht_pkg::SP_100;
    end else if (cmd_i.op == wht_pkg::OP_COMMIT) begin
      rb_prev_q <= rb_q;
      sb_prev_q <= sb_q;
      pb_prev_q <= pb_q;
      heater_q  <= heater_n;
      power_q   <= power_n;
      reheat_q  <= reheat_n;
      idx_q     <= idx_n;
    end
  end

  `WHT_ASSERT_NOW(a_reheat_needs_power, !power_q, !reheat_q, "reheat mode set while power is off")

endmodule

FILE: design/water_heater_thermostat_top.sv
// top level of the water heater thermostat
//
// one request per control tick: three button levels, an adc sample and two
// blink flags arrive on the input channel (in_valid_i / in_stall_o); one
// result with heater, led, horn and saturated temperature leaves on the
// output channel (out_valid_o / out_stall_i). a request is taken when valid
// is high and stall is low
// an accepted request steps through load+square, quadratic term, linear term
// and thermostat update in turn, as the single shared multiplier forms d*d,
// quad*d*d and lin*d one after another; the input stalls while a request
// is in flight
// a finished result sits in the output register while the receiver stalls;
// the next request can be taken and worked on meanwhile, and it waits in its
// final step until the output register frees up
// reset (rst_ni low) clears the modes, the heater and the setpoint index,
// sets the previous button levels high and loads the default coefficients
// coefficients are to be written through the apb-style port while idle; the block does not enforce this
module water_heater_thermostat_top #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wht_pkg::PADDR_W-1:0] paddr,
  input  logic [wht_pkg::PDATA_W-1:0] pwdata,
  output logic [wht_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        reheat_button_i,
  input  logic                        select_button_i,
  input  logic                        power_button_i,
  input  logic [ADC_BITS-1:0]         adc_sample_i,
  input  logic                        blink_slow_i,
  input  logic                        blink_horn_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        heater_drive_o,
  output logic                        led_power_o,
  output logic                        led_reheat_o,
  output logic                        led_forty_o,
  output logic                        led_sixty_o,
  output logic                        led_eighty_o,
  output logic                        led_hundred_o,
  output logic                        horn_on_o,
  output logic signed [15:0]          temperature_o
);

  wht_pkg::cfg_t cfg;
  wht_pkg::cmd_t cmd;

  // coefficient and threshold registers
  wht_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: load+square, quadratic term, linear term, update
  wht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // arithmetic, thermostat state and result registers
  wht_dp #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_i           (cfg),
    .reheat_button_i (reheat_button_i),
    .select_button_i (select_button_i),
    .power_button_i  (power_button_i),
    .adc_sample_i    (adc_sample_i),
    .blink_slow_i    (blink_slow_i),
    .blink_horn_i    (blink_horn_i),
    .heater_drive_o  (heater_drive_o),
    .led_power_o     (led_power_o),
    .led_reheat_o    (led_reheat_o),
    .led_forty_o     (led_forty_o),
    .led_sixty_o     (led_sixty_o),
    .led_eighty_o    (led_eighty_o),
    .led_hundred_o   (led_hundred_o),
    .horn_on_o       (horn_on_o),
    .temperature_o   (temperature_o)
  );

endmodule
